FILE: sv/v92_trellis_coset_encoder_macros.svh
// Assertion macros used by the trellis coset encoder top level.
`ifndef V92_TRELLIS_COSET_ENCODER_MACROS_SVH
`define V92_TRELLIS_COSET_ENCODER_MACROS_SVH

// Check that post holds in the cycle after pre.
`define V92TCE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("v92tce next-cycle check failed");

// Check that post holds in the same cycle as pre.
`define V92TCE_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("v92tce same-cycle check failed");

`endif

FILE: sv/v92tce_pkg.sv
// Package: mode codes, label tables and the result type of the trellis coset encoder.
`timescale 1ns / 1ps
package v92tce_pkg;

   typedef enum logic [1:0] {
      MODE_S16  = 2'd0,
      MODE_S32  = 2'd1,
      MODE_S64  = 2'd2,
      MODE_HOLD = 2'd3
   } mode_type;

   localparam int PointWidth = 16;
   localparam int StateWidth = 6;
   localparam int LabelWidth = 4;
   localparam int SubsetWidth = 3;

   localparam logic [SubsetWidth-1:0] SUBSET_LAB [16] = '{
      3'd0, 3'd7, 3'd4, 3'd3, 3'd5, 3'd2, 3'd1, 3'd6,
      3'd4, 3'd3, 3'd0, 3'd7, 3'd1, 3'd6, 3'd5, 3'd2
   };

   localparam logic [LabelWidth-1:0] COSET4D [64] = '{
      4'd0,  4'd0,  4'd1,  4'd1,  4'd8,  4'd8,  4'd9,  4'd9,
      4'd3,  4'd2,  4'd2,  4'd3,  4'd11, 4'd10, 4'd10, 4'd11,
      4'd5,  4'd5,  4'd4,  4'd4,  4'd13, 4'd13, 4'd12, 4'd12,
      4'd6,  4'd7,  4'd7,  4'd6,  4'd14, 4'd15, 4'd15, 4'd14,
      4'd8,  4'd8,  4'd9,  4'd9,  4'd0,  4'd0,  4'd1,  4'd1,
      4'd11, 4'd10, 4'd10, 4'd11, 4'd3,  4'd2,  4'd2,  4'd3,
      4'd13, 4'd13, 4'd12, 4'd12, 4'd5,  4'd5,  4'd4,  4'd4,
      4'd14, 4'd15, 4'd15, 4'd14, 4'd6,  4'd7,  4'd7,  4'd6
   };

   typedef struct packed {
      logic                  coded_bit;
      logic [StateWidth-1:0] new_state;
      logic [LabelWidth-1:0] coset_label;
   } step_type;

endpackage

FILE: sv/v92tce_req_if.sv
// Request channel: four signed point values per symbol.
`timescale 1ns / 1ps
interface v92tce_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [v92tce_pkg::PointWidth-1:0] point_a;
   logic signed [v92tce_pkg::PointWidth-1:0] point_b;
   logic signed [v92tce_pkg::PointWidth-1:0] point_c;
   logic signed [v92tce_pkg::PointWidth-1:0] point_d;

   modport source (output valid, point_a, point_b, point_c, point_d, input ready);
   modport sink (input valid, point_a, point_b, point_c, point_d, output ready);
endinterface

FILE: sv/v92tce_rsp_if.sv
// Response channel: coded bit, new trellis state and coset label.
`timescale 1ns / 1ps
interface v92tce_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              coded_bit;
   logic [v92tce_pkg::StateWidth-1:0] new_state;
   logic [v92tce_pkg::LabelWidth-1:0] coset_label;

   modport source (output valid, coded_bit, new_state, coset_label, input ready);
   modport sink (input valid, coded_bit, new_state, coset_label, output ready);
endinterface

FILE: sv/v92tce_csr_if.sv
// Configuration write channel carrying the trellis mode.
`timescale 1ns / 1ps
interface v92tce_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] trellis_mode;

   modport source (output valid, trellis_mode, input ready);
   modport sink (input valid, trellis_mode, output ready);
endinterface

FILE: sv/v92tce_lane.sv
// Lane: reduces a pair of points to residues and looks up their subset label.
`timescale 1ns / 1ps
module v92tce_lane (
   input  logic signed [v92tce_pkg::PointWidth-1:0]  point_lo,
   input  logic signed [v92tce_pkg::PointWidth-1:0]  point_hi,
   output logic        [v92tce_pkg::SubsetWidth-1:0] subset_label
);

   logic [1:0] residue_lo;
   logic [1:0] residue_hi;

   // (x + 2) mod 4 only flips bit 1 of the two low bits
   assign residue_lo = {~point_lo[1], point_lo[0]};
   assign residue_hi = {~point_hi[1], point_hi[0]};

   assign subset_label = v92tce_pkg::SUBSET_LAB[{residue_hi, residue_lo}];

endmodule

FILE: sv/v92tce_merge.sv
// Merge stage: combines lane labels into the 4D coset label and steps the trellis.
`timescale 1ns / 1ps
module v92tce_merge (
   input  logic [v92tce_pkg::SubsetWidth-1:0] label_a,
   input  logic [v92tce_pkg::SubsetWidth-1:0] label_b,
   input  logic [v92tce_pkg::StateWidth-1:0]  state,
   input  v92tce_pkg::mode_type               mode,
   output v92tce_pkg::step_type               result
);

   logic [v92tce_pkg::LabelWidth-1:0] lab;
   logic [v92tce_pkg::StateWidth-1:0] ns;
   logic                              y;

   assign lab = v92tce_pkg::COSET4D[{label_a, label_b}];

   always_comb begin
      ns = state;
      y  = 1'b0;
      unique case (mode)
         v92tce_pkg::MODE_S16: begin
            y  = state[2] ^ lab[0];
            ns = {2'b00, y, state[1] ^ lab[1], state[0] ^ state[3] ^ lab[1], state[3]};
         end
         v92tce_pkg::MODE_S32: begin
            y  = state[3] ^ lab[1];
            ns = {1'b0, y, state[2] ^ lab[3], state[1] ^ lab[0], state[0] ^ lab[1],
                  state[4]};
         end
         v92tce_pkg::MODE_S64: begin
            y  = state[4] ^ state[2] ^ lab[1];
            ns = {y, state[5], state[2], state[1] ^ lab[0] ^ state[2],
                  state[0] ^ state[1] ^ state[3] ^ lab[2] ^ (state[2] & lab[1]),
                  state[0] ^ state[1] ^ (state[2] & (state[1] ^ lab[0])) ^ lab[3]};
         end
         default: begin
            // unused mode: hold the state, coded bit low
            ns = state;
            y  = 1'b0;
         end
      endcase
   end

   assign result.coded_bit   = y;
   assign result.new_state   = ns;
   assign result.coset_label = lab;

endmodule

FILE: sv/v92_trellis_coset_encoder.sv
// Top level of the V.92 4D trellis coset encoder.
//
//   channel | dir | payload                                 | handshake
//   req     | in  | point_a, point_b, point_c, point_d      | valid/ready
//   rsp     | out | coded_bit, new_state, coset_label       | valid/ready
//   csr     | in  | trellis_mode (also clears trellis state) | valid/ready
//
// One request per cycle while req.ready is high; its response appears in
// the cycle after acceptance; state feeds back through the merge stage.
// Synchronous active-high reset clears mode to 16 states and state to zero.
// req.ready stays high while the response register is empty or being taken.
`timescale 1ns / 1ps
`include "v92_trellis_coset_encoder_macros.svh"
module v92_trellis_coset_encoder (
   input logic         clock,
   input logic         reset,
   v92tce_req_if.sink  req,
   v92tce_rsp_if.source rsp,
   v92tce_csr_if.sink  csr
);

   logic [v92tce_pkg::SubsetWidth-1:0] label_a;
   logic [v92tce_pkg::SubsetWidth-1:0] label_b;
   v92tce_pkg::step_type               step;

   v92tce_pkg::mode_type               mode_ff, mode_in;
   logic [v92tce_pkg::StateWidth-1:0]  state_ff, state_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   v92tce_pkg::step_type               rsp_data_ff, rsp_data_in;
   logic                               req_take;

   v92tce_lane u_lane_ab (
      .point_lo     (req.point_a),
      .point_hi     (req.point_b),
      .subset_label (label_a)
   );

   v92tce_lane u_lane_cd (
      .point_lo     (req.point_c),
      .point_hi     (req.point_d),
      .subset_label (label_b)
   );

   v92tce_merge u_merge (
      .label_a (label_a),
      .label_b (label_b),
      .state   (state_ff),
      .mode    (mode_ff),
      .result  (step)
   );

   assign req.ready = ~rsp_valid_ff | rsp.ready;
   assign csr.ready = 1'b1;
   assign req_take  = req.valid & req.ready;

   always_comb begin
      mode_in      = mode_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         state_in     = step.new_state;
         rsp_valid_in = 1'b1;
         rsp_data_in  = step;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      // mode write wins: clear the state
      if (csr.valid) begin
         mode_in  = v92tce_pkg::mode_type'(csr.trellis_mode);
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= v92tce_pkg::MODE_S16;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.coded_bit   = rsp_data_ff.coded_bit;
   assign rsp.new_state   = rsp_data_ff.new_state;
   assign rsp.coset_label = rsp_data_ff.coset_label;

   `V92TCE_ASSERT_NEXT(a_csr_clears_state, clock, reset, csr.valid, state_ff == '0)
   `V92TCE_ASSERT_NEXT(a_rsp_tracks_state, clock, reset, req_take && !csr.valid, rsp.valid && rsp.new_state == state_ff)
   `V92TCE_ASSERT_NEXT(a_hold_mode_zero_bit, clock, reset, req_take && mode_ff == v92tce_pkg::MODE_HOLD, !rsp.coded_bit)
   `V92TCE_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid_ff, req.ready)

endmodule

FILE: dv/v92_trellis_coset_encoder_checker.sv
// Checker for the trellis coset encoder: predicts each response and compares it.
`timescale 1ns / 1ps
module v92_trellis_coset_encoder_checker (
   input  logic         clock,
   input  logic         reset,
   v92tce_req_if        req,
   v92tce_rsp_if        rsp,
   v92tce_csr_if        csr,
   output int           mismatch_count,
   output int           pending_count
);

   localparam logic [2:0] SubsetLabel [16] = '{
      3'd0, 3'd7, 3'd4, 3'd3, 3'd5, 3'd2, 3'd1, 3'd6,
      3'd4, 3'd3, 3'd0, 3'd7, 3'd1, 3'd6, 3'd5, 3'd2
   };

   localparam logic [3:0] CosetLabel [64] = '{
      4'd0,  4'd0,  4'd1,  4'd1,  4'd8,  4'd8,  4'd9,  4'd9,
      4'd3,  4'd2,  4'd2,  4'd3,  4'd11, 4'd10, 4'd10, 4'd11,
      4'd5,  4'd5,  4'd4,  4'd4,  4'd13, 4'd13, 4'd12, 4'd12,
      4'd6,  4'd7,  4'd7,  4'd6,  4'd14, 4'd15, 4'd15, 4'd14,
      4'd8,  4'd8,  4'd9,  4'd9,  4'd0,  4'd0,  4'd1,  4'd1,
      4'd11, 4'd10, 4'd10, 4'd11, 4'd3,  4'd2,  4'd2,  4'd3,
      4'd13, 4'd13, 4'd12, 4'd12, 4'd5,  4'd5,  4'd4,  4'd4,
      4'd14, 4'd15, 4'd15, 4'd14, 4'd6,  4'd7,  4'd7,  4'd6
   };

   v92tce_pkg::mode_type              cur_mode;
   logic [v92tce_pkg::StateWidth-1:0] cur_state;
   v92tce_pkg::step_type              pending_steps [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic v92tce_pkg::step_type encode_symbol(input v92tce_pkg::mode_type mode,
                                                          input logic [5:0] s,
                                                          input logic [15:0] pa, pb, pc, pd);
      logic [1:0] r0, r1, r2, r3;
      logic [2:0] lab_a, lab_b;
      logic [3:0] lab;
      logic [5:0] ns;
      logic       y;
      v92tce_pkg::step_type res;
      // residue (x + 2) mod 4 needs only the two low bits
      r0 = pa[1:0] + 2'd2;
      r1 = pb[1:0] + 2'd2;
      r2 = pc[1:0] + 2'd2;
      r3 = pd[1:0] + 2'd2;
      lab_a = SubsetLabel[{r1, r0}];
      lab_b = SubsetLabel[{r3, r2}];
      lab = CosetLabel[{lab_a, lab_b}];
      ns = s;
      y = 1'b0;
      case (mode)
         v92tce_pkg::MODE_S16: begin
            y  = s[2] ^ lab[0];
            ns = {2'b00, y, s[1] ^ lab[1], s[0] ^ s[3] ^ lab[1], s[3]};
         end
         v92tce_pkg::MODE_S32: begin
            y  = s[3] ^ lab[1];
            ns = {1'b0, y, s[2] ^ lab[3], s[1] ^ lab[0], s[0] ^ lab[1], s[4]};
         end
         v92tce_pkg::MODE_S64: begin
            y  = s[4] ^ s[2] ^ lab[1];
            ns = {y, s[5], s[2], s[1] ^ lab[0] ^ s[2],
                  s[0] ^ s[1] ^ s[3] ^ lab[2] ^ (s[2] & lab[1]),
                  s[0] ^ s[1] ^ (s[2] & (s[1] ^ lab[0])) ^ lab[3]};
         end
         // unused mode: hold the state, coded bit low
         default: ;
      endcase
      res.coded_bit   = y;
      res.new_state   = ns;
      res.coset_label = lab;
      return res;
   endfunction

   always @(posedge clock) begin
      v92tce_pkg::step_type want;
      if (reset) begin
         pending_steps.delete();
         cur_mode  = v92tce_pkg::MODE_S16;
         cur_state = '0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_steps.size() == 0) begin
               report_mismatch("response with no request pending");
            end else begin
               want = pending_steps.pop_front();
               if (rsp.coded_bit !== want.coded_bit)
                  report_mismatch($sformatf("coded_bit got %0b expected %0b",
                                            rsp.coded_bit, want.coded_bit));
               if (rsp.new_state !== want.new_state)
                  report_mismatch($sformatf("new_state got %0d expected %0d",
                                            rsp.new_state, want.new_state));
               if (rsp.coset_label !== want.coset_label)
                  report_mismatch($sformatf("coset_label got %0d expected %0d",
                                            rsp.coset_label, want.coset_label));
            end
         end
         // a mode write also clears the trellis state
         if (csr.valid && csr.ready) begin
            cur_mode  = v92tce_pkg::mode_type'(csr.trellis_mode);
            cur_state = '0;
         end
         if (req.valid && req.ready) begin
            want = encode_symbol(cur_mode, cur_state, req.point_a, req.point_b,
                                 req.point_c, req.point_d);
            cur_state = want.new_state;
            pending_steps.push_back(want);
         end
      end
      pending_count = pending_steps.size();
   end

endmodule

FILE: dv/v92_trellis_coset_encoder_tb.sv
// Testbench top for the trellis coset encoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module v92_trellis_coset_encoder_tb;

   localparam int NumPhases = 8;
   localparam int PhaseSymbols = 88;
   localparam v92tce_pkg::mode_type PhaseModes [NumPhases] = '{
      v92tce_pkg::MODE_S32, v92tce_pkg::MODE_S64, v92tce_pkg::MODE_S16,
      v92tce_pkg::MODE_HOLD, v92tce_pkg::MODE_S64, v92tce_pkg::MODE_S16,
      v92tce_pkg::MODE_S32, v92tce_pkg::MODE_S64
   };

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;
   int   send_gap_pct;
   int   stall_pct;
   int   holdoff_req;

   v92tce_req_if req ();
   v92tce_rsp_if rsp ();
   v92tce_csr_if csr ();

   v92_trellis_coset_encoder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   v92_trellis_coset_encoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .csr            (csr),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #2400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off when asked.
   initial begin
      int n;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req > 0) begin
            n = holdoff_req;
            holdoff_req = 0;
            rsp.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp.ready = ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [15:0] pick_point();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(7)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_symbol(input logic [15:0] pa, pb, pc, pd);
      while ($urandom_range(99) < send_gap_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid   = 1'b1;
      req.point_a = pa;
      req.point_b = pb;
      req.point_c = pc;
      req.point_d = pd;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic drain_requests();
      req.valid = 1'b0;
      wait (pending_count == 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_mode(input v92tce_pkg::mode_type mode);
      drain_requests();
      csr.valid        = 1'b1;
      csr.trellis_mode = mode;
      do @(posedge clock); while (!csr.ready);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   initial begin
      req.valid        = 1'b0;
      req.point_a      = '0;
      req.point_b      = '0;
      req.point_c      = '0;
      req.point_d      = '0;
      csr.valid        = 1'b0;
      csr.trellis_mode = v92tce_pkg::MODE_S16;
      send_gap_pct     = 0;
      stall_pct        = 0;
      holdoff_req      = 0;
      reset            = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // reset mode is 16 states; hit extremes and negative residues
      send_symbol(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
      send_symbol(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
      send_symbol(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_symbol(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_symbol(16'h0001, 16'h0002, 16'h0003, 16'hFFFE);
      send_symbol(16'hFFFD, 16'hFFFC, 16'h0004, 16'h0005);
      send_symbol(16'h7FFE, 16'h8001, 16'h7FFD, 16'h8002);
      send_symbol(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
      write_mode(v92tce_pkg::MODE_S64);
      send_symbol(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_symbol(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_symbol(16'h0002, 16'hFFFE, 16'h0001, 16'hFFFF);
      send_symbol(16'h1234, 16'hEDCB, 16'h4321, 16'hBCDE);
      write_mode(v92tce_pkg::MODE_HOLD);
      send_symbol(16'h0003, 16'h0001, 16'hFFFE, 16'h7FFF);
      send_symbol(16'h8000, 16'h0002, 16'hFFFF, 16'h0000);

      for (int ph = 0; ph < NumPhases; ph++) begin
         write_mode(PhaseModes[ph]);
         case (ph % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 57; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 57; end
            default: begin send_gap_pct = 20; stall_pct = 20; end
         endcase
         for (int i = 0; i < PhaseSymbols; i++) begin
            // hold off responses while requests keep coming, to back up the input
            if (ph == 0 && i == 30) holdoff_req = 150;
            // pause the request side until every response is back
            if (ph == 2 && i == 44) drain_requests();
            send_symbol(pick_point(), pick_point(), pick_point(), pick_point());
         end
      end

      req.valid = 1'b0;
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
